// File: rtl/nfid_pkg.sv
// ----------------------------------------------------------------------------
// nfid_pkg
// shared widths, codes and sequencer states of the next-fit id allocator
// ----------------------------------------------------------------------------
package nfid_pkg;

	localparam int NUM_IDS_DEF = 64;
	localparam int ID_W        = 6;
	localparam int COUNT_W     = 7;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_FULL     = 2'd1,
		ST_RELEASED = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_REL_RD,
		S_REL_CHK,
		S_RESP
	} state_t;

endpackage

// File: rtl/nfid_if.sv
// ----------------------------------------------------------------------------
// nfid_req_if / nfid_rsp_if
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
interface nfid_req_if;
	logic                       valid;
	logic                       ready;
	nfid_pkg::cmd_t             cmd;
	logic [nfid_pkg::ID_W-1:0]  release_id;

	modport source (output valid, output cmd, output release_id, input ready);
	modport sink   (input valid, input cmd, input release_id, output ready);
endinterface

interface nfid_rsp_if;
	logic                          valid;
	logic                          ready;
	nfid_pkg::status_t             status;
	logic [nfid_pkg::ID_W-1:0]     granted_id;
	logic [nfid_pkg::COUNT_W-1:0]  live_count;

	modport source (output valid, output status, output granted_id, output live_count,
		input ready);
	modport sink   (input valid, input status, input granted_id, input live_count,
		output ready);
endinterface

// File: rtl/nfid_bitmap.sv
// ----------------------------------------------------------------------------
// nfid_bitmap
// single-port in-use bitmap, one bit per id, registered read
// ----------------------------------------------------------------------------
module nfid_bitmap #(
	parameter int NUM_IDS = nfid_pkg::NUM_IDS_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(NUM_IDS)-1:0] addr,
	input  logic                       wdata,
	output logic                       rdata
);
	logic mem [NUM_IDS];

	// read-first: rdata shows the bit before any write in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/next_fit_id_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_id_allocator
// next-fit allocator over a bitmap of NUM_IDS identifiers with live count
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                            | handshake
//  --------+-----+------------------------------------+-------------
//  req     | in  | cmd, release_id                    | valid/ready
//  rsp     | out | status, granted_id, live_count     | valid/ready
//
//  after reset a clearing pass writes every bitmap entry to free, req.ready low
//  allocate: an accept step, then per probed entry a memory read and a check
//  and mark, at most NUM_IDS entries, then a response step
//  pool full, or release of an out-of-range id: accept, then response
//  release: accept, read, check and clear, response
//  the single bitmap port serialises the steps; one request is in work at a time
//  the response register lets a new request in while the last response waits;
//  that request stalls in its response step until rsp is taken
//
module next_fit_id_allocator #(
	parameter int NUM_IDS = nfid_pkg::NUM_IDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nfid_req_if.sink   req,
	nfid_rsp_if.source rsp
);
	import nfid_pkg::*;

	localparam int PTR_W  = $clog2(NUM_IDS);
	localparam int CNT_W  = $clog2(NUM_IDS + 1);
	localparam int IDX_W  = (PTR_W > ID_W) ? PTR_W : ID_W;
	localparam int CNTX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	localparam logic [PTR_W-1:0] LAST_ID  = PTR_W'(NUM_IDS - 1);
	localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(NUM_IDS);
	localparam logic [CNT_W-1:0] LAST_PRB = CNT_W'(NUM_IDS - 1);

	// sequencer state
	state_t state_q, state_d;

	// allocator state
	logic [PTR_W-1:0] search_q;     // next-fit pointer, left on the last grant
	logic [CNT_W-1:0] count_q;      // ids in use

	// working registers of the request in flight
	logic [PTR_W-1:0] pos_q;        // scan position, also the clear address
	logic [CNT_W-1:0] probe_q;      // entries already probed
	logic [PTR_W-1:0] rid_q;
	status_t          status_q;
	logic [PTR_W-1:0] gid_q;

	// response register
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [PTR_W-1:0] rsp_gid_q;
	logic [CNT_W-1:0] rsp_count_q;

	// bitmap port
	logic             bm_we;
	logic [PTR_W-1:0] bm_addr;
	logic             bm_wdata;
	logic             bm_rdata;

	logic             req_fire;
	logic             rid_in_range;
	logic [IDX_W-1:0] rid_ext;
	logic             pool_full;
	logic             last_probe;
	logic             resp_load;
	logic [PTR_W-1:0] pos_next;
	logic [IDX_W-1:0] gid_ext;
	logic [CNTX_W-1:0] count_ext;

	nfid_bitmap #(
		.NUM_IDS(NUM_IDS)
	) u_bitmap (
		.clk  (clk),
		.we   (bm_we),
		.addr (bm_addr),
		.wdata(bm_wdata),
		.rdata(bm_rdata)
	);

	assign req_fire     = req.valid && req.ready;
	assign rid_ext      = IDX_W'(req.release_id);
	assign rid_in_range = 32'(req.release_id) < NUM_IDS;
	assign pool_full    = count_q >= POOL_CNT;
	assign last_probe   = probe_q == LAST_PRB;
	// the shared step unit: wrap-around increment of the scan position
	assign pos_next     = (pos_q == LAST_ID) ? '0 : pos_q + 1'b1;
	// response waits for a free output register
	assign resp_load    = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (pos_q == LAST_ID) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = pool_full ? S_RESP : S_SCAN_RD;
					end else begin
						state_d = rid_in_range ? S_REL_RD : S_RESP;
					end
				end
			end
			S_SCAN_RD:  state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (!bm_rdata || last_probe) state_d = S_RESP;
				else                         state_d = S_SCAN_RD;
			end
			S_REL_RD:  state_d = S_REL_CHK;
			S_REL_CHK: state_d = S_RESP;
			S_RESP: begin
				if (resp_load) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// outputs of the sequencer: request ready and bitmap port
	always_comb begin
		req.ready = 1'b0;
		bm_we     = 1'b0;
		bm_addr   = pos_q;
		bm_wdata  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				bm_we = 1'b1;
			end
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_SCAN_RD: begin
				bm_addr = pos_q;
			end
			S_SCAN_CHK: begin
				// free entry found: mark it used
				bm_we    = !bm_rdata;
				bm_wdata = 1'b1;
			end
			S_REL_RD: begin
				bm_addr = rid_q;
			end
			S_REL_CHK: begin
				// only a live id is cleared
				bm_addr = rid_q;
				bm_we   = bm_rdata;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			search_q    <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			case (state_q)
				S_CLEAR: begin
					pos_q <= pos_next;
				end
				S_IDLE: begin
					if (req_fire) begin
						pos_q <= search_q;
					end
				end
				S_SCAN_CHK: begin
					if (!bm_rdata) begin
						search_q <= pos_q;
						count_q  <= count_q + 1'b1;
					end else if (!last_probe) begin
						pos_q <= pos_next;
					end
				end
				S_REL_CHK: begin
					if (bm_rdata && count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (resp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working and response payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				probe_q <= '0;
				rid_q   <= rid_ext[PTR_W-1:0];
				gid_q   <= '0;
				if (req.cmd == CMD_ALLOC) status_q <= ST_FULL;
				else                      status_q <= ST_UNUSED;
			end
			S_SCAN_CHK: begin
				probe_q <= probe_q + 1'b1;
				if (!bm_rdata) begin
					status_q <= ST_GRANTED;
					gid_q    <= pos_q;
				end
			end
			S_REL_CHK: begin
				if (bm_rdata) status_q <= ST_RELEASED;
			end
			default: begin
			end
		endcase

		if (resp_load) begin
			rsp_status_q <= status_q;
			rsp_gid_q    <= gid_q;
			rsp_count_q  <= count_q;
		end
	end

	assign gid_ext   = IDX_W'(rsp_gid_q);
	assign count_ext = CNTX_W'(rsp_count_q);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.granted_id = gid_ext[ID_W-1:0];
	assign rsp.live_count = count_ext[COUNT_W-1:0];

endmodule

// File: rtl/nfid_checker.sv
// ----------------------------------------------------------------------------
// nfid_checker
// port-level checks of the next-fit id allocator, bound to the top level
// ----------------------------------------------------------------------------
module nfid_checker #(
	parameter int NUM_IDS = nfid_pkg::NUM_IDS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input nfid_pkg::status_t             rsp_status,
	input logic [nfid_pkg::ID_W-1:0]     rsp_granted_id,
	input logic [nfid_pkg::COUNT_W-1:0]  rsp_live_count
);
	import nfid_pkg::*;

	localparam logic [COUNT_W-1:0] POOL = COUNT_W'(NUM_IDS);

	// stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_granted_id) && $stable(rsp_live_count))
		else $error("response changed while stalled");

	// one request in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// only a grant carries an id
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_GRANTED |-> rsp_granted_id == '0)
		else $error("id shown on a response that is not a grant");

	// pool full only when every id is live
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_live_count == POOL)
		else $error("pool full reported below the pool size");

endmodule

bind next_fit_id_allocator nfid_checker #(
	.NUM_IDS(NUM_IDS)
) u_nfid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_granted_id(rsp.granted_id),
	.rsp_live_count(rsp.live_count)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the next-fit id allocator: a directed table of
// allocate and release requests with typed answers for the plain cases,
// then random requests steered toward empty, full and partly filled pools, every
// response checked against a bitmap model of the pool kept in the bench
// ----------------------------------------------------------------------------
module tb;

	import nfid_pkg::*;

	localparam int NUM_IDS        = NUM_IDS_DEF;
	localparam int RANDOM_ITEMS   = 970;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF       = 300;
	localparam int N_DIRECTED     = 17;

	// one expected response
	typedef struct packed {
		status_t              status;
		logic [ID_W-1:0]      id;
		logic [COUNT_W-1:0]   count;
	} alloc_resp_t;

	// one row of the directed table; reps repeats the request, typed marks a
	// row whose answer is written out by hand instead of taken from the model
	typedef struct {
		cmd_t              cmd;
		logic [ID_W-1:0]   rid;
		int                reps;
		bit                typed;
		alloc_resp_t       want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nfid_req_if req_ch ();
	nfid_rsp_if rsp_ch ();

	next_fit_id_allocator #(
		.NUM_IDS (NUM_IDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// bench copy of the pool
	bit [NUM_IDS-1:0] pool_in_use;
	int               probe_start;
	int               pool_live;

	// responses still owed by the block, oldest first
	alloc_resp_t awaited_responses [$];

	int mismatches  = 0;
	int idle_cycles = 0;

	// the directed walk: grant from empty, release of a free id, next-fit
	// behavior after a release behind the pointer, filling to the top id,
	// wrap to zero, pool full, worst-case scan, alternating id bit patterns
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_ALLOC,   6'd0,  1,  1'b1, '{ST_GRANTED,  6'd0,  7'd1}},
		'{CMD_RELEASE, 6'd63, 1,  1'b1, '{ST_UNUSED,   6'd0,  7'd1}},
		'{CMD_RELEASE, 6'd0,  1,  1'b1, '{ST_RELEASED, 6'd0,  7'd0}},
		'{CMD_RELEASE, 6'd0,  1,  1'b1, '{ST_UNUSED,   6'd0,  7'd0}},
		'{CMD_ALLOC,   6'd63, 1,  1'b1, '{ST_GRANTED,  6'd0,  7'd1}},
		'{CMD_ALLOC,   6'd0,  1,  1'b0, '{ST_GRANTED,  6'd0,  7'd0}},
		'{CMD_RELEASE, 6'd0,  1,  1'b1, '{ST_RELEASED, 6'd0,  7'd1}},
		'{CMD_ALLOC,   6'd0,  1,  1'b0, '{ST_GRANTED,  6'd0,  7'd0}},
		'{CMD_ALLOC,   6'd0,  61, 1'b0, '{ST_GRANTED,  6'd0,  7'd0}},
		'{CMD_ALLOC,   6'd0,  1,  1'b1, '{ST_GRANTED,  6'd0,  7'd64}},
		'{CMD_ALLOC,   6'd63, 1,  1'b1, '{ST_FULL,     6'd0,  7'd64}},
		'{CMD_RELEASE, 6'd63, 1,  1'b1, '{ST_RELEASED, 6'd0,  7'd63}},
		'{CMD_ALLOC,   6'd0,  1,  1'b0, '{ST_GRANTED,  6'd0,  7'd0}},
		'{CMD_RELEASE, 6'd21, 1,  1'b1, '{ST_RELEASED, 6'd0,  7'd63}},
		'{CMD_RELEASE, 6'd42, 1,  1'b1, '{ST_RELEASED, 6'd0,  7'd62}},
		'{CMD_RELEASE, 6'd42, 1,  1'b1, '{ST_UNUSED,   6'd0,  7'd62}},
		'{CMD_ALLOC,   6'd0,  1,  1'b0, '{ST_GRANTED,  6'd0,  7'd0}}
	};

	// apply one request to the bench pool and return the response it owes
	function automatic alloc_resp_t allocate_or_release(cmd_t c, logic [ID_W-1:0] rid);
		alloc_resp_t r;
		int          pos;
		bit          found;
		r.status = ST_FULL;
		r.id     = '0;
		found    = 1'b0;
		if (c == CMD_ALLOC) begin
			// full pool answers at once and touches nothing
			if (pool_live < NUM_IDS) begin
				pos = probe_start;
				for (int n = 0; n < NUM_IDS && !found; n++) begin
					if (!pool_in_use[pos]) begin
						pool_in_use[pos] = 1'b1;
						probe_start      = pos;
						pool_live++;
						r.status         = ST_GRANTED;
						r.id             = pos[ID_W-1:0];
						found            = 1'b1;
					end else begin
						pos = (pos + 1) % NUM_IDS;
					end
				end
			end
		end else if (rid < NUM_IDS && pool_in_use[rid]) begin
			// release keeps the search pointer where it is
			pool_in_use[rid] = 1'b0;
			if (pool_live > 0)
				pool_live--;
			r.status = ST_RELEASED;
		end else begin
			r.status = ST_UNUSED;
		end
		r.count = pool_live[COUNT_W-1:0];
		return r;
	endfunction

	// pick some id that is in use, scanning from a random point
	function automatic logic [ID_W-1:0] pick_used_id();
		int start;
		int pos;
		start = $urandom_range(0, NUM_IDS - 1);
		for (int n = 0; n < NUM_IDS; n++) begin
			pos = (start + n) % NUM_IDS;
			if (pool_in_use[pos])
				return pos[ID_W-1:0];
		end
		return start[ID_W-1:0];
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// offer one request after an idle gap and wait until it is taken; valid is
	// left high so a back-to-back request keeps it asserted
	task automatic send_request(input cmd_t c, input logic [ID_W-1:0] rid, input int gap,
		input bit typed, input alloc_resp_t want);
		alloc_resp_t modeled;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.release_id <= rid;
		do @(posedge clk); while (!req_ch.ready);
		modeled = allocate_or_release(c, rid);
		awaited_responses.push_back(typed ? want : modeled);
	endtask

	task automatic flag_mismatch(input string what);
		if (mismatches < 10)
			$display("mismatch: %s", what);
		mismatches++;
	endtask

	// response side: check each taken response, then choose next ready
	initial begin : response_sink
		int          stall;
		int          seen;
		bit          held;
		alloc_resp_t want;
		stall = 0;
		seen  = 0;
		held  = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen++;
				if (awaited_responses.size() == 0) begin
					flag_mismatch($sformatf("response with none awaited: status %0d id %0d count %0d",
						rsp_ch.status, rsp_ch.granted_id, rsp_ch.live_count));
				end else begin
					want = awaited_responses.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.granted_id !== want.id ||
						rsp_ch.live_count !== want.count)
						flag_mismatch($sformatf(
							"response %0d: expected status %0d id %0d count %0d, got %0d %0d %0d",
							seen, want.status, want.id, want.count,
							rsp_ch.status, rsp_ch.granted_id, rsp_ch.live_count));
				end
			end
			// one long hold-off so the block fills up and stalls requests
			if (!held && seen == 150) begin
				held  = 1'b1;
				stall = HOLD_OFF;
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				// stretches with ready held high throughout
				if ((seen % 250) >= 50)
					stall = random_gap();
			end
		end
	end

	// watchdog: cycles in a row with no request and no response taken
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("next_fit_id_allocator test failed");
			$finish;
		end
	end

	// request side: reset, directed table, random requests, drain, verdict
	initial begin : request_source
		int          target;
		int          gap;
		bit          do_alloc;
		cmd_t        c;
		logic [ID_W-1:0] rid;
		alloc_resp_t none;
		none              = '0;
		target            = 0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_ALLOC;
		req_ch.release_id = '0;
		pool_in_use       = '0;
		probe_start       = 0;
		pool_live         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			for (int n = 0; n < directed_rows[k].reps; n++)
				send_request(directed_rows[k].cmd, directed_rows[k].rid, random_gap(),
					directed_rows[k].typed, directed_rows[k].want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// every 60 requests steer toward a new occupancy: empty, full or between
			if (i % 60 == 0) begin
				case ($urandom_range(0, 3))
					0:       target = 0;
					1:       target = NUM_IDS;
					default: target = $urandom_range(0, NUM_IDS);
				endcase
			end
			if (pool_live < target)
				do_alloc = ($urandom_range(0, 99) < 85);
			else
				do_alloc = ($urandom_range(0, 99) < 15);
			c = do_alloc ? CMD_ALLOC : CMD_RELEASE;
			// releases mostly hit a live id, some are arbitrary
			if (!do_alloc && $urandom_range(0, 99) < 85)
				rid = pick_used_id();
			else
				rid = ID_W'($urandom_range(0, NUM_IDS - 1));
			// back-to-back bursts at the start of every 200 requests
			gap = ((i % 200) < 40) ? 0 : random_gap();
			send_request(c, rid, gap, 1'b0, none);
		end
		req_ch.valid <= 1'b0;

		while (awaited_responses.size() != 0)
			@(posedge clk);
		// room for anything stray still in flight
		repeat (2 * NUM_IDS + 8) @(posedge clk);

		if (mismatches == 0)
			$display("next_fit_id_allocator test passed");
		else
			$display("next_fit_id_allocator test failed");
		$finish;
	end

endmodule
